FILE: rtl/hce_pkg.sv
// ============================================================================
// HCL colormap evaluator package
// Shared constants, types and elaboration-time table generators.
// ============================================================================
package hce_pkg;

    localparam int POW_TABLE_BITS_DEF = 6;
    localparam int NSTG               = 10;

    localparam int HUE_LIMIT   = 23040;
    localparam int SECTOR      = 3840;
    localparam int HALF_SECTOR = 1920;
    localparam int Q15_ONE     = 32768;
    localparam int EXP_LINEAR  = 4096;
    // 15 * RECIP15 = 2^20 - 1.
    localparam int RECIP15     = 69905;

    typedef enum logic [2:0] {
        CFG_HUE_ZERO    = 3'd0,
        CFG_HUE_ONE     = 3'd1,
        CFG_CHROMA_ZERO = 3'd2,
        CFG_CHROMA_ONE  = 3'd3,
        CFG_LUMI_ZERO   = 3'd4,
        CFG_LUMI_ONE    = 3'd5,
        CFG_CHROMA_EXP  = 3'd6,
        CFG_LUMI_EXP    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [14:0] hue_zero;
        logic [14:0] hue_one;
        logic [15:0] chroma_zero;
        logic [15:0] chroma_one;
        logic [15:0] lumi_zero;
        logic [15:0] lumi_one;
        logic [15:0] chroma_exp;
        logic [15:0] lumi_exp;
    } t_cfg;

    typedef struct packed {
        t_sector     sector;
        logic [11:0] sect_pos;
        logic        in_range;
        logic        last;
    } t_hue_tag;

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned bt;
        v  = v_in;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // log2(1 + i / 2^bits) in Q.16, by repeated squaring.
    function automatic longint unsigned log_sample(longint unsigned i, int bits);
        longint unsigned x;
        longint unsigned res;
        x   = (64'd1 << 30) + (i << (30 - bits));
        res = 0;
        if (x >= (64'd1 << 31)) begin
            res = 64'd65536;
            x   = x >> 1;
        end
        for (int b = 15; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x   = x >> 1;
                res = res | (64'd1 << b);
            end
        end
        return res;
    endfunction

    // 2^(-j / 2^bits) in Q0.30, as a product of successive square roots.
    function automatic longint unsigned exp_sample(longint unsigned j, int bits);
        longint unsigned roots [0:10];
        longint unsigned acc;
        for (int m = 0; m <= 10; m++) roots[m] = 0;
        roots[0] = 64'd1 << 29;
        for (int m = 1; m <= bits; m++) roots[m] = isqrt64(roots[m-1] << 30);
        acc = 64'd1 << 30;
        for (int k = 0; k <= bits; k++) begin
            if (((j >> k) & 64'd1) != 0) acc = (acc * roots[bits-k]) >> 30;
        end
        return acc;
    endfunction

endpackage

FILE: rtl/hce_in_if.sv
// ============================================================================
// Stop item channel
// Carries one gradient stop position and its last-stop mark.
// ============================================================================
interface hce_in_if;
    logic        valid;
    logic        ready;
    logic [16:0] stop_position;
    logic        last_stop;

    modport source (output valid, stop_position, last_stop, input ready);
    modport sink   (input valid, stop_position, last_stop, output ready);
endinterface

FILE: rtl/hce_out_if.sv
// ============================================================================
// Color item channel
// Carries one RGB color with its range flag and last mark.
// ============================================================================
interface hce_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        hue_in_range;
    logic        last;

    modport source (output valid, red, green, blue, hue_in_range, last, input ready);
    modport sink   (input valid, red, green, blue, hue_in_range, last, output ready);
endinterface

FILE: rtl/hce_power.sv
// ============================================================================
// Power unit
// Five-stage t^e in Q0.16 through table-interpolated log2 and exp2.
// ============================================================================
module hce_power import hce_pkg::*; #(
    parameter int POW_TABLE_BITS = POW_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic [4:0]  i_en,
    input  logic [16:0] i_stop,
    input  logic [15:0] i_expo,
    output logic [16:0] o_pow
);

    localparam int SH   = 16 - POW_TABLE_BITS;
    localparam int NENT = (1 << POW_TABLE_BITS) + 1;
    localparam int IW   = POW_TABLE_BITS;

    logic [16:0] w_log_tab [NENT];
    logic [30:0] w_exp_tab [NENT];

    for (genvar g = 0; g < NENT; g++) begin : g_tab
        localparam logic [16:0] LV = 17'(log_sample(g, POW_TABLE_BITS));
        localparam logic [30:0] EV = 31'(exp_sample(g, POW_TABLE_BITS));
        assign w_log_tab[g] = LV;
        assign w_exp_tab[g] = EV;
    end

    // Stage 1: special cases and normalization.
    logic [3:0]  w_k;
    logic [31:0] w_norm;
    logic        n1_sp;
    logic [16:0] n1_spv;
    logic        r1_sp;
    logic [16:0] r1_spv;
    logic [4:0]  r1_nk;
    logic [15:0] r1_f;

    always_comb begin
        w_k = '0;
        for (int b = 0; b < 16; b++) begin
            if (i_stop[b]) w_k = 4'(b);
        end
        w_norm = {16'd0, i_stop[15:0]} << (5'd16 - {1'b0, w_k});
        n1_sp  = 1'b1;
        n1_spv = 17'd65536;
        if (i_expo == 16'(EXP_LINEAR)) begin
            n1_spv = i_stop;
        end else if (i_expo == 16'd0) begin
            n1_spv = 17'd65536;
        end else if (i_stop == 17'd0) begin
            n1_spv = 17'd0;
        end else if (i_stop[16]) begin
            n1_spv = 17'd65536;
        end else begin
            n1_sp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sp  <= n1_sp;
            r1_spv <= n1_spv;
            r1_nk  <= 5'd16 - {1'b0, w_k};
            r1_f   <= w_norm[15:0];
        end
    end

    // Stage 2: -log2 t.
    logic [IW-1:0] w2_i;
    logic [SH-1:0] w2_rem;
    logic [16:0]   w2_a;
    logic [16:0]   w2_b;
    logic [16:0]   w2_diff;
    logic [16+SH:0] w2_prod;
    logic [16:0]   w2_lf;
    logic          r2_sp;
    logic [16:0]   r2_spv;
    logic [20:0]   r2_l;

    always_comb begin
        w2_i    = r1_f[15:SH];
        w2_rem  = r1_f[SH-1:0];
        w2_a    = w_log_tab[w2_i];
        w2_b    = w_log_tab[(IW+1)'(w2_i) + (IW+1)'(1)];
        w2_diff = w2_b - w2_a;
        w2_prod = (17+SH)'(w2_diff) * (17+SH)'(w2_rem);
        w2_lf   = w2_a + 17'(w2_prod >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sp  <= r1_sp;
            r2_spv <= r1_spv;
            r2_l   <= {r1_nk, 16'd0} - 21'(w2_lf);
        end
    end

    // Stage 3: scale by the exponent.
    logic [37:0] w3_prod;
    logic [24:0] w3_d;
    logic        r3_sp;
    logic [16:0] r3_spv;
    logic        r3_zero;
    logic [4:0]  r3_n;
    logic [15:0] r3_g;

    always_comb begin
        w3_prod = 38'(r2_l) * 38'(i_expo) + 38'd2048;
        w3_d    = w3_prod[36:12];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_sp   <= r2_sp;
            r3_spv  <= r2_spv;
            r3_zero <= (w3_d[24:16] >= 9'd17);
            r3_n    <= w3_d[20:16];
            r3_g    <= w3_d[15:0];
        end
    end

    // Stage 4: exp2 of the fraction.
    logic [IW-1:0] w4_i;
    logic [SH-1:0] w4_rem;
    logic [30:0]   w4_a;
    logic [30:0]   w4_b;
    logic [25:0]   w4_diff;
    logic [25+SH:0] w4_prod;
    logic          r4_sp;
    logic [16:0]   r4_spv;
    logic          r4_zero;
    logic [4:0]    r4_n;
    logic [30:0]   r4_val;

    always_comb begin
        w4_i    = r3_g[15:SH];
        w4_rem  = r3_g[SH-1:0];
        w4_a    = w_exp_tab[w4_i];
        w4_b    = w_exp_tab[(IW+1)'(w4_i) + (IW+1)'(1)];
        w4_diff = 26'(w4_a - w4_b);
        w4_prod = (26+SH)'(w4_diff) * (26+SH)'(w4_rem);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_sp   <= r3_sp;
            r4_spv  <= r3_spv;
            r4_zero <= r3_zero;
            r4_n    <= r3_n;
            r4_val  <= w4_a - 31'(w4_prod >> SH);
        end
    end

    // Stage 5: integer shift with rounding.
    logic [31:0] w5_rnd;
    logic [16:0] n5_pow;
    logic [16:0] r5_pow;

    always_comb begin
        w5_rnd = 32'(r4_val) + (32'd1 << (6'd13 + 6'(r4_n)));
        n5_pow = 17'(w5_rnd >> (6'd14 + 6'(r4_n)));
        if (r4_sp) begin
            n5_pow = r4_spv;
        end else if (r4_zero) begin
            n5_pow = 17'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) r5_pow <= n5_pow;
    end

    assign o_pow = r5_pow;

endmodule

FILE: rtl/hce_color.sv
// ============================================================================
// Color unit
// Blends chroma and luminance, then converts hue sector to saturated RGB.
// ============================================================================
module hce_color import hce_pkg::*; (
    input  logic        i_clk,
    input  logic [4:0]  i_en,
    input  t_cfg        i_cfg,
    input  logic [16:0] i_chroma_pow,
    input  logic [16:0] i_lumi_pow,
    input  logic [11:0] i_dist,
    input  t_sector     i_sector,
    input  logic        i_in_range,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);

    function automatic logic [15:0] blend(logic [15:0] z, logic [15:0] o, logic [16:0] p);
        logic [15:0] zc;
        logic [15:0] oc;
        logic [33:0] s;
        zc = (z > 16'(Q15_ONE)) ? 16'(Q15_ONE) : z;
        oc = (o > 16'(Q15_ONE)) ? 16'(Q15_ONE) : o;
        s  = 34'(zc) * 34'(17'd65536 - p) + 34'(oc) * 34'(p) + 34'd32768;
        return s[31:16];
    endfunction

    function automatic logic [15:0] to_q16(logic [16:0] v);
        return v[16] ? 16'hFFFF : (v[15] ? 16'hFFFF : {v[14:0], 1'b0});
    endfunction

    // Stage 6: blended chroma and luminance.
    logic [15:0] r6_ch;
    logic [15:0] r6_lu;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r6_ch <= blend(i_cfg.chroma_zero, i_cfg.chroma_one, i_chroma_pow);
            r6_lu <= blend(i_cfg.lumi_zero, i_cfg.lumi_one, i_lumi_pow);
        end
    end

    // Stage 7: chroma scaled by luminance.
    logic [32:0] w7_prod;
    logic [15:0] r7_c;
    logic [15:0] r7_lu;

    assign w7_prod = 33'(r6_lu) * 33'(r6_ch) + 33'd16384;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r7_c  <= w7_prod[30:15];
            r7_lu <= r6_lu;
        end
    end

    // Stage 8: offset and the in-sector product.
    logic [15:0] r8_c;
    logic [15:0] r8_m;
    logic [27:0] r8_cw;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r8_c  <= r7_c;
            r8_m  <= r7_lu - r7_c;
            r8_cw <= 28'(r7_c) * 28'(i_dist) + 28'(HALF_SECTOR);
        end
    end

    // Stage 9: divide by 3840 as a shift by 256 and a reciprocal of 15.
    logic [19:0] w9_num;
    logic [36:0] w9_prod;
    logic [15:0] r9_c;
    logic [15:0] r9_m;
    logic [19:0] r9_num;
    logic [16:0] r9_q;

    assign w9_num  = r8_cw[27:8];
    assign w9_prod = 37'(w9_num) * 37'(RECIP15);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r9_c   <= r8_c;
            r9_m   <= r8_m;
            r9_num <= w9_num;
            r9_q   <= w9_prod[36:20];
        end
    end

    // Stage 10: quotient correction, channel select and saturation.
    logic [20:0] w10_rem;
    logic [15:0] w10_x;
    logic [15:0] w10_r;
    logic [15:0] w10_g;
    logic [15:0] w10_b;
    logic [15:0] r10_red;
    logic [15:0] r10_green;
    logic [15:0] r10_blue;

    always_comb begin
        w10_rem = 21'(r9_num) - ({r9_q, 4'd0} - 21'(r9_q));
        w10_x   = (w10_rem >= 21'd15) ? 16'(r9_q + 17'd1) : 16'(r9_q);
        w10_r   = '0;
        w10_g   = '0;
        w10_b   = '0;
        unique case (i_sector)
            SEC_RY: begin w10_r = r9_c;  w10_g = w10_x; end
            SEC_YG: begin w10_r = w10_x; w10_g = r9_c;  end
            SEC_GC: begin w10_g = r9_c;  w10_b = w10_x; end
            SEC_CB: begin w10_g = w10_x; w10_b = r9_c;  end
            SEC_BM: begin w10_r = w10_x; w10_b = r9_c;  end
            default: begin w10_r = r9_c; w10_b = w10_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r10_red   <= i_in_range ? to_q16(17'(w10_r) + 17'(r9_m)) : 16'd0;
            r10_green <= i_in_range ? to_q16(17'(w10_g) + 17'(r9_m)) : 16'd0;
            r10_blue  <= i_in_range ? to_q16(17'(w10_b) + 17'(r9_m)) : 16'd0;
        end
    end

    assign o_red   = r10_red;
    assign o_green = r10_green;
    assign o_blue  = r10_blue;

endmodule

FILE: rtl/hcl_colormap_evaluator_unit.sv
// ============================================================================
// HCL colormap evaluator
// Maps a gradient stop position to an RGB color along an HCL palette.
// ============================================================================
// The block takes one stop item per clock and returns one color item per
// clock while the output is not stalled. Each stop item passes through ten
// register stages: stop clamp with hue and normalization, the power units
// (log2 table, exponent multiply, exp2 table, shift) and the color path
// (blend, chroma scale, sector product, divide, select).
// Each stage holds its item while the one after it is full and held, so a stall at
// the output fills empty stages first and loses nothing.
module hcl_colormap_evaluator_unit import hce_pkg::*; #(
    parameter int POW_TABLE_BITS = POW_TABLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    hce_in_if.sink       i_in,
    hce_out_if.source    o_out
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_zero    <= 15'd3840;
            r_cfg.hue_one     <= 15'd0;
            r_cfg.chroma_zero <= 16'd19661;
            r_cfg.chroma_one  <= 16'd32768;
            r_cfg.lumi_zero   <= 16'd29491;
            r_cfg.lumi_one    <= 16'd16384;
            r_cfg.chroma_exp  <= 16'd1638;
            r_cfg.lumi_exp    <= 16'd9011;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HUE_ZERO:    r_cfg.hue_zero    <= i_cfg_data[14:0];
                CFG_HUE_ONE:     r_cfg.hue_one     <= i_cfg_data[14:0];
                CFG_CHROMA_ZERO: r_cfg.chroma_zero <= i_cfg_data;
                CFG_CHROMA_ONE:  r_cfg.chroma_one  <= i_cfg_data;
                CFG_LUMI_ZERO:   r_cfg.lumi_zero   <= i_cfg_data;
                CFG_LUMI_ONE:    r_cfg.lumi_one    <= i_cfg_data;
                CFG_CHROMA_EXP:  r_cfg.chroma_exp  <= i_cfg_data;
                CFG_LUMI_EXP:    r_cfg.lumi_exp    <= i_cfg_data;
            endcase
        end
    end

    // Stage valid bits and per-stage advance.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign i_in.ready = w_en[0];

    // Stage 1: clamp the stop and interpolate hue.
    logic [16:0] w_stop;
    logic [33:0] w_hsum;
    logic [14:0] r_h;
    logic        r_last1;

    assign w_stop = (i_in.stop_position > 17'd65536) ? 17'd65536 : i_in.stop_position;
    assign w_hsum = 34'(r_cfg.hue_zero) * 34'(17'd65536 - w_stop)
                  + 34'(r_cfg.hue_one) * 34'(w_stop) + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_h     <= w_hsum[30:16];
            r_last1 <= i_in.last_stop;
        end
    end

    // Stage 2: hue sector and distance within it, then carried along.
    t_hue_tag n_tag2;
    t_hue_tag r_tag [2:NSTG];
    logic [14:0] w_base;

    always_comb begin
        n_tag2.sector   = SEC_MR;
        w_base          = 15'(5 * SECTOR);
        if (r_h < 15'(SECTOR)) begin
            n_tag2.sector = SEC_RY;
            w_base        = 15'd0;
        end else if (r_h < 15'(2 * SECTOR)) begin
            n_tag2.sector = SEC_YG;
            w_base        = 15'(SECTOR);
        end else if (r_h < 15'(3 * SECTOR)) begin
            n_tag2.sector = SEC_GC;
            w_base        = 15'(2 * SECTOR);
        end else if (r_h < 15'(4 * SECTOR)) begin
            n_tag2.sector = SEC_CB;
            w_base        = 15'(3 * SECTOR);
        end else if (r_h < 15'(5 * SECTOR)) begin
            n_tag2.sector = SEC_BM;
            w_base        = 15'(4 * SECTOR);
        end
        // Odd sectors run downward from the sector's far edge.
        n_tag2.sect_pos = n_tag2.sector[0] ? 12'(15'(SECTOR) - (r_h - w_base))
                                           : 12'(r_h - w_base);
        n_tag2.in_range = (r_h < 15'(HUE_LIMIT));
        n_tag2.last     = r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_tag[2] <= n_tag2;
        for (int k = 3; k <= NSTG; k++) begin
            if (w_en[k-1]) r_tag[k] <= r_tag[k-1];
        end
    end

    logic [16:0] w_chroma_pow;
    logic [16:0] w_lumi_pow;

    hce_power #(.POW_TABLE_BITS(POW_TABLE_BITS)) u_chroma_pow (
        .i_clk  (i_clk),
        .i_en   (w_en[4:0]),
        .i_stop (w_stop),
        .i_expo (r_cfg.chroma_exp),
        .o_pow  (w_chroma_pow)
    );

    hce_power #(.POW_TABLE_BITS(POW_TABLE_BITS)) u_lumi_pow (
        .i_clk  (i_clk),
        .i_en   (w_en[4:0]),
        .i_stop (w_stop),
        .i_expo (r_cfg.lumi_exp),
        .o_pow  (w_lumi_pow)
    );

    logic [15:0] w_red;
    logic [15:0] w_green;
    logic [15:0] w_blue;

    hce_color u_color (
        .i_clk        (i_clk),
        .i_en         (w_en[9:5]),
        .i_cfg        (r_cfg),
        .i_chroma_pow (w_chroma_pow),
        .i_lumi_pow   (w_lumi_pow),
        .i_dist       (r_tag[7].sect_pos),
        .i_sector     (r_tag[9].sector),
        .i_in_range   (r_tag[9].in_range),
        .o_red        (w_red),
        .o_green      (w_green),
        .o_blue       (w_blue)
    );

    assign o_out.valid        = r_vld[NSTG-1];
    assign o_out.red          = w_red;
    assign o_out.green        = w_green;
    assign o_out.blue         = w_blue;
    assign o_out.hue_in_range = r_tag[NSTG].in_range;
    assign o_out.last         = r_tag[NSTG].last;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_mid_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !w_en[4] |=> r_vld[4])
        else $error("stalled item left the power stage");

    a_black_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.hue_in_range |->
            (o_out.red == 16'd0 && o_out.green == 16'd0 && o_out.blue == 16'd0))
        else $error("hue out of range but color not black");

endmodule

FILE: tb/tb_hcl_colormap_evaluator_unit.sv
// ============================================================================
// HCL colormap evaluator testbench
// Drives stop items through the evaluator and checks every color item
// against a bit-exact predictor or a typed-in color, over several register settings and idling.
// ============================================================================
module tb_hcl_colormap_evaluator_unit;
    import hce_pkg::*;

    localparam int PTB      = POW_TABLE_BITS_DEF;
    localparam int LATENCY  = 10;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        hue_in_range;
        logic        last;
    } t_color;

    typedef struct {
        logic [16:0] stop;
        logic        last;
        logic        has_color;
        t_color      color;
    } t_stop_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    hce_in_if  stop_ch ();
    hce_out_if color_ch ();

    hcl_colormap_evaluator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (stop_ch.sink),
        .o_out      (color_ch.source)
    );

    // Predictor copy of the registers.
    t_cfg cfg;

    t_color colors_due [$];
    int     errors;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     recv_hold;
    bit     timed_out;

    longint unsigned log_tab [0:(1<<PTB)];
    longint unsigned exp_tab [0:(1<<PTB)];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // t^e in Q0.16 through the log2 / exp2 sample tables.
    function automatic longint unsigned stop_power(longint unsigned t, longint unsigned e);
        longint unsigned frac, idx, rem, a, b, lf, lg, dd, n, g, val;
        int k;
        if (e == EXP_LINEAR) return t;
        if (e == 0) return 65536;
        if (t == 0) return 0;
        if (t >= 65536) return 65536;
        k = 15;
        while (((t >> k) & 1) == 0) k--;
        frac = (t << (16 - k)) - 65536;
        idx  = frac >> (16 - PTB);
        rem  = frac & ((64'd1 << (16 - PTB)) - 1);
        a    = log_tab[idx];
        b    = log_tab[idx + 1];
        lf   = a + (((b - a) * rem) >> (16 - PTB));
        lg   = longint'(16 - k) * 65536 - lf;
        dd   = (lg * e + 2048) >> 12;
        n    = dd >> 16;
        if (n >= 17) return 0;
        g    = dd & 16'hFFFF;
        idx  = g >> (16 - PTB);
        rem  = g & ((64'd1 << (16 - PTB)) - 1);
        a    = exp_tab[idx];
        b    = exp_tab[idx + 1];
        val  = a - (((a - b) * rem) >> (16 - PTB));
        return (val + (64'd1 << (13 + n))) >> (14 + n);
    endfunction

    function automatic longint unsigned mix_q15(longint unsigned z, longint unsigned o,
                                                longint unsigned p);
        if (z > Q15_ONE) z = Q15_ONE;
        if (o > Q15_ONE) o = Q15_ONE;
        return (z * (65536 - p) + o * p + 32768) >> 16;
    endfunction

    function automatic logic [15:0] sat_q16(longint unsigned v);
        v = v << 1;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_color predict_color(logic [16:0] stop, logic last);
        longint unsigned t, h, ch, lu, c, m, s, rem, w, x, r, g, b;
        t_color col;
        t = stop;
        if (t > 65536) t = 65536;
        h = (longint'(cfg.hue_zero) * (65536 - t) + longint'(cfg.hue_one) * t + 32768) >> 16;
        col = '0;
        col.last = last;
        if (h >= HUE_LIMIT) return col;
        ch = mix_q15(cfg.chroma_zero, cfg.chroma_one, stop_power(t, cfg.chroma_exp));
        lu = mix_q15(cfg.lumi_zero, cfg.lumi_one, stop_power(t, cfg.lumi_exp));
        c   = (lu * ch + 16384) >> 15;
        m   = lu - c;
        s   = h / SECTOR;
        rem = h - s * SECTOR;
        w   = s[0] ? SECTOR - rem : rem;
        x   = (c * w + HALF_SECTOR) / SECTOR;
        r = 0; g = 0; b = 0;
        case (t_sector'(s[2:0]))
            SEC_RY: begin r = c; g = x; end
            SEC_YG: begin r = x; g = c; end
            SEC_GC: begin g = c; b = x; end
            SEC_CB: begin g = x; b = c; end
            SEC_BM: begin r = x; b = c; end
            default: begin r = c; b = x; end
        endcase
        col.red          = sat_q16(r + m);
        col.green        = sat_q16(g + m);
        col.blue         = sat_q16(b + m);
        col.hue_in_range = 1'b1;
        return col;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HUE_ZERO:    cfg.hue_zero    = data[14:0];
            CFG_HUE_ONE:     cfg.hue_one     = data[14:0];
            CFG_CHROMA_ZERO: cfg.chroma_zero = data;
            CFG_CHROMA_ONE:  cfg.chroma_one  = data;
            CFG_LUMI_ZERO:   cfg.lumi_zero   = data;
            CFG_LUMI_ONE:    cfg.lumi_one    = data;
            CFG_CHROMA_EXP:  cfg.chroma_exp  = data;
            default:         cfg.lumi_exp    = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Offers one item; the expected color is queued when it is accepted.
    task automatic send_stop(logic [16:0] stop, logic last, bit has_color, t_color color);
        t_color due;
        while ($urandom_range(99) < send_idle_pct) begin
            stop_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        stop_ch.valid         <= 1'b1;
        stop_ch.stop_position <= stop;
        stop_ch.last_stop     <= last;
        @(posedge i_clk);
        while (!stop_ch.ready) @(posedge i_clk);
        due = has_color ? color : predict_color(stop, last);
        colors_due.insert(colors_due.size(), due);
    endtask

    task automatic end_burst();
        stop_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [16:0] rand_stop();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'(65536 + $urandom_range(65535));
            3: return 17'($urandom_range(255));
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_q15();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [15:0] rand_exp();
        case ($urandom_range(6))
            0: return 16'd0;
            1: return 16'(EXP_LINEAR);
            2: return 16'hFFFF;
            3: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(16384));
        endcase
    endfunction

    task automatic random_setting();
        write_reg(CFG_HUE_ZERO, 16'($urandom_range(1) ? $urandom_range(23039)
                                                       : $urandom_range(32767)));
        write_reg(CFG_HUE_ONE, 16'($urandom_range(1) ? $urandom_range(23039)
                                                      : $urandom_range(32767)));
        write_reg(CFG_CHROMA_ZERO, rand_q15());
        write_reg(CFG_CHROMA_ONE, rand_q15());
        write_reg(CFG_LUMI_ZERO, rand_q15());
        write_reg(CFG_LUMI_ONE, rand_q15());
        write_reg(CFG_CHROMA_EXP, rand_exp());
        write_reg(CFG_LUMI_EXP, rand_exp());
    endtask

    task automatic random_items(int count);
        for (int i = 0; i < count; i++)
            send_stop(rand_stop(), 1'($urandom_range(1)), 1'b0, '0);
        end_burst();
    endtask

    // Output side: stall as set for the phase, and check each accepted color.
    always @(posedge i_clk) begin
        t_color got, want;
        if (!i_rst_n) begin
            color_ch.ready <= 1'b0;
        end else begin
            if (color_ch.valid && color_ch.ready) begin
                got = {color_ch.red, color_ch.green, color_ch.blue,
                       color_ch.hue_in_range, color_ch.last};
                if (colors_due.size() == 0) begin
                    $display("%0t: unexpected color item %h", $time, got);
                    errors++;
                end else begin
                    want = colors_due.pop_front();
                    if (got.red !== want.red)
                        $display("%0t: red exp %h got %h", $time, want.red, got.red);
                    if (got.green !== want.green)
                        $display("%0t: green exp %h got %h", $time, want.green, got.green);
                    if (got.blue !== want.blue)
                        $display("%0t: blue exp %h got %h", $time, want.blue, got.blue);
                    if (got.hue_in_range !== want.hue_in_range)
                        $display("%0t: hue_in_range exp %b got %b", $time,
                                 want.hue_in_range, got.hue_in_range);
                    if (got.last !== want.last)
                        $display("%0t: last exp %b got %b", $time, want.last, got.last);
                    if (got !== want) errors++;
                end
            end
            color_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (stop_ch.valid && stop_ch.ready) ||
            (color_ch.valid && color_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) timed_out <= 1'b1;
    end

    // Long hold-off on the receiver, counted here while the sender keeps going.
    task automatic hold_receiver(int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        recv_hold = 1'b0;
    endtask

    task automatic run_test();
        t_stop_row rows [0:7];
        t_color blank;
        // After reset: stop zero gives luminance and chroma at their zero values
        // and hue 60 degrees; no color is typed in, every row is checked against
        // the predictor.
        blank = '0;
        rows[0] = '{17'd0,     1'b0, 1'b0, blank};
        rows[1] = '{17'd65536, 1'b1, 1'b0, blank};
        rows[2] = '{17'h1FFFF, 1'b0, 1'b0, blank};
        rows[3] = '{17'd1,     1'b1, 1'b0, blank};
        rows[4] = '{17'd32768, 1'b0, 1'b0, blank};
        rows[5] = '{17'h0FFFF, 1'b1, 1'b0, blank};
        rows[6] = '{17'h15555, 1'b0, 1'b0, blank};
        rows[7] = '{17'h0AAAA, 1'b1, 1'b0, blank};
        foreach (rows[i]) send_stop(rows[i].stop, rows[i].last, rows[i].has_color,
                                    rows[i].color);
        end_burst();
        wait_drained();

        // Hue out of range: both ends at the top of the field give black.
        write_reg(CFG_HUE_ZERO, 16'h7FFF);
        write_reg(CFG_HUE_ONE, 16'h7FFF);
        send_stop(17'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1});
        send_stop(17'd65536, 1'b0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0});
        end_burst();
        wait_drained();

        // Exponent zero, registers above one, hue just below the limit.
        write_reg(CFG_HUE_ZERO, 16'd23039);
        write_reg(CFG_HUE_ONE, 16'd0);
        write_reg(CFG_CHROMA_ZERO, 16'hFFFF);
        write_reg(CFG_CHROMA_ONE, 16'd0);
        write_reg(CFG_LUMI_ZERO, 16'hFFFF);
        write_reg(CFG_LUMI_ONE, 16'd32768);
        write_reg(CFG_CHROMA_EXP, 16'd0);
        write_reg(CFG_LUMI_EXP, 16'hFFFF);
        foreach (rows[i]) send_stop(rows[i].stop, rows[i].last, 1'b0, blank);
        send_stop(17'd3, 1'b0, 1'b0, blank);
        send_stop(17'd65535, 1'b1, 1'b0, blank);
        end_burst();
        wait_drained();

        // Random settings over the idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int s = 0; s < 4; s++) begin
                random_setting();
                random_items(60);
                wait_drained();
            end
        end

        // Output held off while the input keeps offering, then a full pause.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(200);
            random_items(40);
        join
        wait_drained();
        random_items(20);
        wait_drained();
    endtask

    initial begin
        errors = 0;
        timed_out = 1'b0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i <= (1 << PTB); i++) begin
            log_tab[i] = log_sample(i, PTB);
            exp_tab[i] = exp_sample(i, PTB);
        end
        cfg = '{15'd3840, 15'd0, 16'd19661, 16'd32768, 16'd29491, 16'd16384,
                16'd1638, 16'd9011};
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_HUE_ZERO;
        i_cfg_data            = '0;
        stop_ch.valid         = 1'b0;
        stop_ch.stop_position = '0;
        stop_ch.last_stop     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            run_test();
            wait (timed_out);
        join_any
        if (timed_out) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            if (errors == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
